[rtl/mke_pkg.sv]
// shared types, constants and the morse lookup tables for the keying encoder
// no dependencies
`default_nettype none

package mke_pkg;

	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);
	localparam int CodeW = 5;

	localparam logic [7:0] ChSpace = 8'd32;
	localparam logic [7:0] ChFirstDigit = 8'd48;
	localparam logic [7:0] ChLastDigit = 8'd57;
	localparam logic [7:0] ChFirstUpper = 8'd65;
	localparam logic [7:0] ChLastUpper = 8'd90;
	localparam logic [7:0] ChFirstLower = 8'd97;
	localparam logic [7:0] ChLastLower = 8'd122;
	localparam logic [7:0] CaseFold = 8'd32;

	localparam logic [1:0] KEY_OFF = 2'd0;
	localparam logic [1:0] KEY_ON = 2'd1;
	localparam logic [1:0] SYM_DOT = 2'd0;
	localparam logic [1:0] SYM_DASH = 2'd1;
	localparam logic [1:0] SYM_GAP = 2'd2;

	// one classified character: a word gap or a code of len elements, msb first
	typedef struct packed {
		logic is_space;
		logic [2:0] len;
		logic [CodeW-1:0] bits;
	} desc_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ELEM,
		PH_TAIL
	} phase_t;

	function automatic desc_t mk_code(input logic [2:0] len, input logic [CodeW-1:0] bits);
		desc_t d;
		d.is_space = 1'b0;
		d.len = len;
		d.bits = bits;
		return d;
	endfunction

	function automatic desc_t letter_code(input logic [4:0] idx);
		desc_t d;
		case (idx)
			5'd0: d = mk_code(3'd2, 5'h01);
			5'd1: d = mk_code(3'd4, 5'h08);
			5'd2: d = mk_code(3'd4, 5'h0A);
			5'd3: d = mk_code(3'd3, 5'h04);
			5'd4: d = mk_code(3'd1, 5'h00);
			5'd5: d = mk_code(3'd4, 5'h02);
			5'd6: d = mk_code(3'd3, 5'h06);
			5'd7: d = mk_code(3'd4, 5'h00);
			5'd8: d = mk_code(3'd2, 5'h00);
			5'd9: d = mk_code(3'd4, 5'h07);
			5'd10: d = mk_code(3'd3, 5'h05);
			5'd11: d = mk_code(3'd4, 5'h04);
			5'd12: d = mk_code(3'd2, 5'h03);
			5'd13: d = mk_code(3'd2, 5'h02);
			5'd14: d = mk_code(3'd3, 5'h07);
			5'd15: d = mk_code(3'd4, 5'h06);
			5'd16: d = mk_code(3'd4, 5'h0D);
			5'd17: d = mk_code(3'd3, 5'h02);
			5'd18: d = mk_code(3'd3, 5'h00);
			5'd19: d = mk_code(3'd1, 5'h01);
			5'd20: d = mk_code(3'd3, 5'h01);
			5'd21: d = mk_code(3'd4, 5'h01);
			5'd22: d = mk_code(3'd3, 5'h03);
			5'd23: d = mk_code(3'd4, 5'h09);
			5'd24: d = mk_code(3'd4, 5'h0B);
			5'd25: d = mk_code(3'd4, 5'h0C);
			default: d = mk_code(3'd1, 5'h00);
		endcase
		return d;
	endfunction

	function automatic desc_t digit_code(input logic [3:0] idx);
		desc_t d;
		case (idx)
			4'd0: d = mk_code(3'd5, 5'h1F);
			4'd1: d = mk_code(3'd5, 5'h0F);
			4'd2: d = mk_code(3'd5, 5'h07);
			4'd3: d = mk_code(3'd5, 5'h03);
			4'd4: d = mk_code(3'd5, 5'h01);
			4'd5: d = mk_code(3'd5, 5'h00);
			4'd6: d = mk_code(3'd5, 5'h10);
			4'd7: d = mk_code(3'd5, 5'h18);
			4'd8: d = mk_code(3'd5, 5'h1C);
			4'd9: d = mk_code(3'd5, 5'h1E);
			default: d = mk_code(3'd1, 5'h00);
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[rtl/mke_front.sv]
// front end: case folding, character classification and morse table lookup
// depends on mke_pkg
`default_nettype none

module mke_front
	import mke_pkg::*;
(
	input  wire logic       push,
	input  wire logic [7:0] char_code,
	input  wire logic       q_full,
	output logic            full,
	output logic            wr_en,
	output desc_t           wr_desc
);

	logic [7:0] ch;
	logic       supported;
	logic [7:0] letter_off;
	logic [7:0] digit_off;

	always_comb begin
		ch = char_code;
		if (char_code inside {[ChFirstLower:ChLastLower]}) begin
			ch = char_code - CaseFold;
		end
		letter_off = ch - ChFirstUpper;
		digit_off = ch - ChFirstDigit;
		supported = 1'b1;
		wr_desc = mk_code(3'd1, '0);
		if (ch == ChSpace) begin
			wr_desc.is_space = 1'b1;
		end else if (ch inside {[ChFirstUpper:ChLastUpper]}) begin
			wr_desc = letter_code(letter_off[4:0]);
		end else if (ch inside {[ChFirstDigit:ChLastDigit]}) begin
			wr_desc = digit_code(digit_off[3:0]);
		end else begin
			supported = 1'b0;
		end
	end

	// unsupported characters are taken and dropped
	assign full = q_full;
	assign wr_en = push && !q_full && supported;

endmodule

`default_nettype wire

[rtl/mke_queue.sv]
// short descriptor queue between the front end and the serializer
// depends on mke_pkg
`default_nettype none

module mke_queue
	import mke_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  desc_t     wr_desc,
	input  wire logic rd_en,
	output logic      full,
	output logic      rd_valid,
	output desc_t     rd_desc
);

	desc_t           mem_q [QDepth];
	logic [QAw-1:0]  wr_ptr_q;
	logic [QAw-1:0]  rd_ptr_q;
	logic [QAw:0]    count_q;
	logic            do_wr;
	logic            do_rd;

	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;
	assign full = (count_q == (QAw+1)'(QDepth));
	assign rd_valid = (count_q != '0);
	assign rd_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAw+1)'(QDepth))
		else $error("queue count out of range");

	a_wr_moves: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow write");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |=> !(rd_ptr_q != $past(rd_ptr_q)))
		else $error("queue read while empty");

endmodule

`default_nettype wire

[rtl/mke_back.sv]
// back end: serializes one descriptor into keying bits or symbols, one beat a cycle while pop keeps up
// depends on mke_pkg; holds the output mode register and the result register
`default_nettype none

module mke_back
	import mke_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       output_mode,
	input  wire logic       q_valid,
	input  desc_t           q_desc,
	output logic            q_rd,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      out_value,
	output logic            last_of_run
);

	phase_t          phase_q, phase_d;
	logic            mode_q;
	logic            space_q, space_d;
	logic [2:0]      rem_q, rem_d;
	logic [1:0]      cnt_q, cnt_d;
	logic [CodeW-1:0] bits_q, bits_d;
	logic            out_valid_q;
	logic [1:0]      out_value_q;
	logic            out_last_q;

	logic            dash;
	logic [1:0]      end_cnt;
	logic [1:0]      val;
	logic            last;
	logic            step_end;
	logic            step_en;
	logic            load;

	assign cfg_ready = 1'b1;

	always_comb begin
		dash = bits_q[CodeW-1];
		if (phase_q == PH_ELEM) begin
			end_cnt = mode_q ? 2'd0 : (dash ? 2'd3 : 2'd1);
			if (mode_q) begin
				val = dash ? SYM_DASH : SYM_DOT;
			end else begin
				val = (cnt_q == end_cnt) ? KEY_OFF : KEY_ON;
			end
			last = 1'b0;
		end else begin
			end_cnt = space_q ? 2'd3 : (mode_q ? 2'd0 : 2'd1);
			val = mode_q ? SYM_GAP : KEY_OFF;
			last = (cnt_q == end_cnt);
		end
		step_end = (cnt_q == end_cnt);
		step_en = (phase_q != PH_IDLE) && (!out_valid_q || pop);
		load = q_valid && ((phase_q == PH_IDLE) || (step_en && last));

		phase_d = phase_q;
		space_d = space_q;
		rem_d = rem_q;
		cnt_d = cnt_q;
		bits_d = bits_q;
		if (step_en) begin
			if (step_end) begin
				cnt_d = '0;
				if (phase_q == PH_ELEM) begin
					bits_d = bits_q << 1;
					rem_d = rem_q - 1'b1;
					if (rem_q == 3'd1) begin
						phase_d = PH_TAIL;
					end
				end else begin
					phase_d = PH_IDLE;
				end
			end else begin
				cnt_d = cnt_q + 1'b1;
			end
		end
		if (load) begin
			space_d = q_desc.is_space;
			cnt_d = '0;
			rem_d = q_desc.len;
			bits_d = q_desc.bits << (3'(CodeW) - q_desc.len);
			phase_d = q_desc.is_space ? PH_TAIL : PH_ELEM;
		end
	end

	assign q_rd = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			space_q <= 1'b0;
			rem_q <= '0;
			cnt_q <= '0;
			bits_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= output_mode;
			end
			space_q <= space_d;
			rem_q <= rem_d;
			cnt_q <= cnt_d;
			bits_q <= bits_d;
			if (step_en) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_value_q <= val;
			out_last_q <= last;
		end
	end

	assign empty = !out_valid_q;
	assign out_value = out_value_q;
	assign last_of_run = out_last_q;

	a_elem_has_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ELEM |-> rem_q != 3'd0)
		else $error("element phase with no elements left");

	a_value_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_value_q != 2'd3)
		else $error("illegal result value");

	a_space_to_tail: assert property (@(posedge clk) disable iff (!arst_n)
		load && q_desc.is_space |=> phase_q == PH_TAIL && cnt_q == 2'd0)
		else $error("word gap not started");

endmodule

`default_nettype wire

[rtl/morse_keying_encoder.sv]
// top level of the morse keying encoder: front end, descriptor queue, serializer
// depends on mke_pkg, mke_front, mke_queue, mke_back
// a character's first result passes the queue, the serializer state and the result register
// throughput: one result beat per cycle out of the serializer while pop keeps up; a character
// gives 2 to 22 results, unsupported characters give none
// a four-entry descriptor queue lets input beats be taken while the serializer is busy
// reset (arst_n low) clears the queue, the serializer, the result valid flag and the mode
`default_nettype none

module morse_keying_encoder
	import mke_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       output_mode,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_code,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      out_value,
	output logic            last_of_run
);

	logic  q_full;
	logic  q_wr;
	desc_t q_wr_desc;
	logic  q_rd;
	logic  q_valid;
	desc_t q_rd_desc;

	mke_front u_front (
		.push      (push),
		.char_code (char_code),
		.q_full    (q_full),
		.full      (full),
		.wr_en     (q_wr),
		.wr_desc   (q_wr_desc)
	);

	mke_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_desc  (q_wr_desc),
		.rd_en    (q_rd),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_desc  (q_rd_desc)
	);

	mke_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.output_mode (output_mode),
		.q_valid     (q_valid),
		.q_desc      (q_rd_desc),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.out_value   (out_value),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire
